FILE: rtl/arsl_pkg.sv
`timescale 1ns / 1ps
package arsl_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_IDX_W   = 10;
  localparam int WORD_W      = 32;
  localparam int ENTRY_W     = 2 * WORD_W;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  // read beat in flight from the entry memory
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } scan_tag_t;

  // low bits of a table index, zero-extended when the table is small
  function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W+OUT_IDX_W-1:0] w;
    w = {{OUT_IDX_W{1'b0}}, i};
    return w[OUT_IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/address_range_symbol_lookup_core.sv
`timescale 1ns / 1ps
// Address range match table. Clear, add and lookup beats enter one at a time.
// Clear and add give their result through the done state once the output
// register is free; clear only resets the fill count, since entries past the
// count are never read. A lookup reads the stored entries 0 .. count-1
// through the single read port of the entry memory, one entry per cycle,
// compares each read beat in the match unit, and gives its result once the
// output register is free. The next beat is taken as soon as the previous
// result sits in the output register. The input is stalled while reset is high.
module address_range_symbol_lookup_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        opcode,
  input  logic [31:0]                       address,
  input  logic [31:0]                       range_size,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              found,
  output logic [arsl_pkg::OUT_IDX_W-1:0]    entry_index,
  output logic                              status
);
  import arsl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]           state;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     scan_ptr;
  logic [WORD_W-1:0]    probe;
  scan_tag_t            tag;
  logic                 res_found;
  logic [OUT_IDX_W-1:0] res_index;
  logic                 res_status;

  logic                 accept;
  logic                 table_full;
  logic                 wr_en;
  logic                 rd_en;
  logic [ENTRY_W-1:0]   rd_data;
  logic                 scan_start;
  logic                 hit_any;
  logic [IDX_W-1:0]     hit_idx;
  logic                 out_free;

  assign in_stall   = rst || (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign table_full = (count >= CNT_W'(TABLE_DEPTH));
  assign wr_en      = accept && (opcode == OP_ADD) && !table_full;
  assign rd_en      = (state == S_SCAN) && (scan_ptr < count);
  assign scan_start = accept && (opcode == OP_LOOKUP);
  assign out_free   = !out_valid || !out_stall;

  arsl_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[IDX_W-1:0]),
    .wdata ({address, range_size}),
    .re    (rd_en),
    .raddr (scan_ptr[IDX_W-1:0]),
    .rdata (rd_data)
  );

  arsl_match u_match (
    .clk     (clk),
    .rst     (rst),
    .start   (scan_start),
    .tag     (tag),
    .base    (rd_data[ENTRY_W-1:WORD_W]),
    .length  (rd_data[WORD_W-1:0]),
    .probe   (probe),
    .hit_any (hit_any),
    .hit_idx (hit_idx)
  );

  always_ff @(posedge clk) begin
    tag.idx <= scan_ptr[IDX_W-1:0];
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      scan_ptr  <= '0;
      tag.valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          tag.valid <= 1'b0;
          if (accept) begin
            scan_ptr <= '0;
            if (opcode == OP_LOOKUP) begin
              state <= S_SCAN;
            end else begin
              state <= S_DONE;
              if (opcode == OP_CLEAR) begin
                count <= '0;
              end else if (wr_en) begin
                count <= count + 1'b1;
              end
            end
          end
        end
        S_SCAN: begin
          tag.valid <= rd_en;
          if (rd_en) begin
            scan_ptr <= scan_ptr + 1'b1;
          end else if (!tag.valid) begin
            // last read beat has gone through the compare
            state <= S_DONE;
          end
        end
        S_DONE: begin
          tag.valid <= 1'b0;
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state     <= S_IDLE;
          tag.valid <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      probe      <= address;
      res_found  <= 1'b0;
      res_index  <= '0;
      res_status <= ST_OK;
      if (opcode == OP_ADD) begin
        if (table_full) begin
          res_status <= ST_FULL;
        end else begin
          res_index <= to_out_idx(count[IDX_W-1:0]);
        end
      end
    end else if (state == S_SCAN && !rd_en && !tag.valid) begin
      res_found <= hit_any;
      res_index <= hit_any ? to_out_idx(hit_idx) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      found       <= res_found;
      entry_index <= res_index;
      status      <= res_status;
    end
  end

endmodule

FILE: rtl/arsl_ram.sv
`timescale 1ns / 1ps
module arsl_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/arsl_match.sv
`timescale 1ns / 1ps
module arsl_match (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  arsl_pkg::scan_tag_t              tag,
  input  logic [arsl_pkg::WORD_W-1:0]      base,
  input  logic [arsl_pkg::WORD_W-1:0]      length,
  input  logic [arsl_pkg::WORD_W-1:0]      probe,
  output logic                             hit_any,
  output logic [arsl_pkg::IDX_W-1:0]       hit_idx
);
  import arsl_pkg::*;

  logic [WORD_W:0] range_end;
  logic            hit;

  // 33-bit end, never wraps
  assign range_end = {1'b0, base} + {1'b0, length};
  assign hit = (length != '0) && (probe >= base) && ({1'b0, probe} < range_end);

  always_ff @(posedge clk) begin
    if (rst || start) begin
      hit_any <= 1'b0;
    end else if (tag.valid && hit) begin
      hit_any <= 1'b1;
    end
  end

  // entries arrive in ascending order, so the latest hit wins
  always_ff @(posedge clk) begin
    if (start) begin
      hit_idx <= '0;
    end else if (tag.valid && hit) begin
      hit_idx <= tag.idx;
    end
  end

endmodule

FILE: dv/tb_address_range_symbol_lookup_core.sv
`timescale 1ns / 1ps
module tb_address_range_symbol_lookup_core;
  import arsl_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         TOTAL_BEATS  = 580;
  localparam int         IDLE_LIMIT   = 6000;
  localparam int         DRAIN_CYCLES = TABLE_DEPTH + 40;
  localparam int         N_ROWS       = 23;

  typedef struct packed {
    logic                 found;
    logic [OUT_IDX_W-1:0] entry_index;
    logic                 status;
  } table_reply_t;

  typedef struct packed {
    logic [1:0]   opcode;
    logic [31:0]  address;
    logic [31:0]  range_size;
    logic         typed;
    table_reply_t reply;
  } table_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           opcode = OP_CLEAR;
  logic [31:0]          address = '0;
  logic [31:0]          range_size = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 found;
  logic [OUT_IDX_W-1:0] entry_index;
  logic                 status;

  address_range_symbol_lookup_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .address    (address),
    .range_size (range_size),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .entry_index(entry_index),
    .status     (status)
  );

  // Rows with typed = 0 take their expectation from the table model.
  table_row_t directed_rows [N_ROWS] = '{
    '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 10'd0, ST_OK}},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 10'd0, ST_OK}},
    '{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 10'd0, ST_OK}},
    '{OP_ADD,    32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 10'd0, ST_OK}},
    '{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 10'd0, ST_OK}},
    '{OP_ADD,    32'h0000_1000, 32'h0000_0100, 1'b1, '{1'b0, 10'd1, ST_OK}},
    '{OP_LOOKUP, 32'h0000_1000, 32'h0000_0000, 1'b1, '{1'b1, 10'd1, ST_OK}},
    '{OP_LOOKUP, 32'h0000_10FF, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_LOOKUP, 32'h0000_1100, 32'h0000_0000, 1'b1, '{1'b0, 10'd0, ST_OK}},
    '{OP_LOOKUP, 32'h0000_0FFF, 32'h0000_0000, 1'b0, '0},
    '{OP_ADD,    32'hFFFF_FF00, 32'h0000_0100, 1'b1, '{1'b0, 10'd2, ST_OK}},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 10'd3, ST_OK}},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{OP_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 10'd4, ST_OK}},
    '{OP_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0, '0},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{OP_UNUSED, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 10'd0, ST_OK}},
    '{OP_LOOKUP, 32'h0000_1050, 32'h0000_0000, 1'b0, '0},
    '{OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 10'd0, ST_OK}},
    '{OP_LOOKUP, 32'h0000_1050, 32'h0000_0000, 1'b1, '{1'b0, 10'd0, ST_OK}},
    '{OP_ADD,    32'h0000_0020, 32'h0000_0001, 1'b1, '{1'b0, 10'd0, ST_OK}},
    '{OP_LOOKUP, 32'h0000_0020, 32'h0000_0000, 1'b1, '{1'b1, 10'd0, ST_OK}}
  };

  logic [31:0]  model_base [TABLE_DEPTH] = '{default: '0};
  logic [31:0]  model_len  [TABLE_DEPTH] = '{default: '0};
  int unsigned  model_count = 0;

  table_reply_t expected_replies [$];
  table_reply_t want;
  int           fail_count = 0;
  int           sent_beats = 0;
  int           in_gap_pct = 0;
  bit           quiet_tail = 1'b0;
  int           idle_cycles = 0;
  int           burst_left = 0;
  bit           burst_stalls = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic table_reply_t predict_table_op(input logic [1:0] op,
                                                    input logic [31:0] addr,
                                                    input logic [31:0] size);
    table_reply_t r;
    logic [32:0]  range_end;
    int           i;
    r = '0;
    case (op)
      OP_CLEAR: begin
        for (i = 0; i < TABLE_DEPTH; i++) begin
          model_base[i] = '0;
          model_len[i]  = '0;
        end
        model_count = 0;
      end
      OP_ADD: begin
        if (model_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          model_base[model_count] = addr;
          model_len[model_count]  = size;
          r.entry_index = OUT_IDX_W'(model_count);
          model_count++;
        end
      end
      OP_LOOKUP: begin
        // last hit wins; end of range at 33 bits so it never wraps
        for (i = 0; i < TABLE_DEPTH; i++) begin
          if (model_len[i] != 0) begin
            range_end = {1'b0, model_base[i]} + {1'b0, model_len[i]};
            if (addr >= model_base[i] && {1'b0, addr} < range_end) begin
              r.found       = 1'b1;
              r.entry_index = OUT_IDX_W'(i);
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Probe near the edges of a stored range, inside it, or anywhere.
  function automatic logic [31:0] pick_probe();
    int unsigned e;
    logic [31:0] b;
    logic [31:0] l;
    if (model_count == 0 || $urandom_range(4) == 0) return $urandom;
    e = $urandom_range(model_count - 1);
    b = model_base[e];
    l = model_len[e];
    case ($urandom_range(4))
      0:       return b;
      1:       return b + l - 1;
      2:       return b + l;
      3:       return b - 1;
      default: return (l == 0) ? b : b + ($urandom % l);
    endcase
  endfunction

  task automatic send_beat(input logic [1:0] op, input logic [31:0] addr,
                           input logic [31:0] size, input logic typed,
                           input table_reply_t typed_reply);
    int           gap;
    table_reply_t modeled;
    gap = 0;
    if (!quiet_tail && $urandom_range(99) < in_gap_pct) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    address    <= addr;
    range_size <= size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    modeled = predict_table_op(op, addr, size);
    expected_replies.push_back(typed ? typed_reply : modeled);
    sent_beats++;
  endtask

  task automatic add_random_range();
    logic [31:0] base;
    logic [31:0] len;
    case ($urandom_range(4))
      0:       base = $urandom;
      1:       base = 32'hFFFF_FFFF - $urandom_range(255);
      2:       base = $urandom_range(4095);
      3:       base = (model_count == 0) ? $urandom :
                      model_base[model_count - 1] + $urandom_range(64) - 32;
      default: base = $urandom & 32'hFFFF_0000;
    endcase
    case ($urandom_range(5))
      0:       len = '0;
      1:       len = $urandom_range(1, 16);
      2:       len = $urandom_range(1, 65536);
      3:       len = $urandom;
      4:       len = 32'hFFFF_FFFF - $urandom_range(15);
      default: len = $urandom_range(1, 4096);
    endcase
    send_beat(OP_ADD, base, len, 1'b0, '0);
  endtask

  task automatic random_session();
    int n;
    int k;
    case ($urandom_range(2))
      0:       in_gap_pct = 0;
      1:       in_gap_pct = 15;
      default: in_gap_pct = 50;
    endcase
    if (model_count > 40 || $urandom_range(3) == 0)
      send_beat(OP_CLEAR, $urandom, $urandom, 1'b0, '0);
    n = $urandom_range(0, 10);
    for (k = 0; k < n; k++) add_random_range();
    n = $urandom_range(1, 10);
    for (k = 0; k < n; k++) send_beat(OP_LOOKUP, pick_probe(), $urandom, 1'b0, '0);
    if ($urandom_range(7) == 0) send_beat(OP_UNUSED, $urandom, $urandom, 1'b0, '0);
  endtask

  initial begin
    int  r;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    in_gap_pct = 30;
    for (r = 0; r < N_ROWS; r++)
      send_beat(directed_rows[r].opcode, directed_rows[r].address,
                directed_rows[r].range_size, directed_rows[r].typed,
                directed_rows[r].reply);
    while (sent_beats < TOTAL_BEATS) begin
      quiet_tail = sent_beats >= TOTAL_BEATS - 60;
      random_session();
    end
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected beat: found=%0d entry_index=%0d status=%0d",
                 found, entry_index, status);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found);
            fail_count++;
          end
          if (entry_index !== want.entry_index) begin
            $error("entry_index: expected %0d, actual %0d", want.entry_index, entry_index);
            fail_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            fail_count++;
          end
        end
      end

      // random bursts of stalls and free-running stretches
      if (burst_left == 0) begin
        burst_stalls = !quiet_tail && ($urandom_range(2) == 0);
        burst_left   = burst_stalls ? $urandom_range(1, 16) : $urandom_range(1, 40);
      end
      burst_left--;
      out_stall <= burst_stalls;

      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule

FILE: filelist.f
rtl/arsl_pkg.sv
rtl/arsl_ram.sv
rtl/arsl_match.sv
rtl/address_range_symbol_lookup_core.sv
dv/tb_address_range_symbol_lookup_core.sv
